>>> sv/inverter_run_supervisor_defines.svh
// assertion macros shared by the supervisor checker
`ifndef INVERTER_RUN_SUPERVISOR_DEFINES_SVH
`define INVERTER_RUN_SUPERVISOR_DEFINES_SVH

// same-cycle implication, sampled on the block clock, quiet during reset
`define IRS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on the block clock, quiet during reset
`define IRS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/irs_pkg.sv
// shared types, codes and helpers of the inverter run supervisor
package irs_pkg;

    localparam int FREQ_W  = 17;
    localparam int RATIO_W = 16;
    localparam int CUR_W   = 16;
    localparam int TRIP_W  = 15;
    localparam int CNT_W   = 4;
    localparam int OP_W    = 3;
    localparam int STATE_W = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    // operation codes
    localparam logic [OP_W-1:0] OP_TICK      = 3'd0;
    localparam logic [OP_W-1:0] OP_START     = 3'd1;
    localparam logic [OP_W-1:0] OP_STOP      = 3'd2;
    localparam logic [OP_W-1:0] OP_CLR_FAULT = 3'd3;
    localparam logic [OP_W-1:0] OP_SET_FREQ  = 3'd4;

    // run state codes
    localparam logic [STATE_W-1:0] ST_STOP      = 3'd0;
    localparam logic [STATE_W-1:0] ST_RAMP_DOWN = 3'd1;
    localparam logic [STATE_W-1:0] ST_RAMP_UP   = 3'd2;
    localparam logic [STATE_W-1:0] ST_RAMP_FREQ = 3'd3;
    localparam logic [STATE_W-1:0] ST_RUN       = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RAMP_TICKS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIP_CURRENT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIP_COUNT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FREQ_LOW     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FREQ_HIGH    = 3'd4;

    localparam logic [RATIO_W-1:0] RAMP_TICKS_RST   = 16'd20000;
    localparam logic [TRIP_W-1:0]  TRIP_CURRENT_RST = 15'd5000;
    localparam logic [CNT_W-1:0]   TRIP_COUNT_RST   = 4'd3;
    localparam logic [FREQ_W-1:0]  FREQ_LOW_RST     = 17'd60000;
    localparam logic [FREQ_W-1:0]  FREQ_HIGH_RST    = 17'd120000;
    localparam logic [FREQ_W-1:0]  FREQ_RST         = 17'd120000;
    localparam logic [CNT_W-1:0]   OVER_MAX         = 4'd15;

    typedef struct packed {
        logic [RATIO_W-1:0] ramp_ticks;
        logic [TRIP_W-1:0]  trip_current;
        logic [CNT_W-1:0]   trip_count;
        logic [FREQ_W-1:0]  freq_low;
        logic [FREQ_W-1:0]  freq_high;
    } t_cfg;

    typedef struct packed {
        logic [OP_W-1:0]         operation;
        logic signed [CUR_W-1:0] phase_u_current;
        logic signed [CUR_W-1:0] phase_v_current;
        logic signed [CUR_W-1:0] phase_w_current;
        logic [FREQ_W-1:0]       requested_frequency;
    } t_item;

    // result fields apart from the phase angle, whose width follows the turn size
    typedef struct packed {
        logic [STATE_W-1:0] run_mode;
        logic               fault_flag;
        logic               output_enable;
        logic [RATIO_W-1:0] amplitude_ratio;
        logic [FREQ_W-1:0]  present_frequency;
        logic               cycle_done;
        logic               accepted;
    } t_result;

    // magnitude of a signed current sample, full negative maps to 32768
    function automatic logic [CUR_W-1:0] mag16(input logic [CUR_W-1:0] v);
        return v[CUR_W-1] ? (~v + 16'd1) : v;
    endfunction

endpackage

>>> sv/irs_cfg_regs.sv
// configuration register file of the inverter run supervisor
module irs_cfg_regs
    import irs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_wr,
    input  logic [CFG_IDX_W-1:0]  i_index,
    input  logic [CFG_DATA_W-1:0] i_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_wr) begin
            unique case (i_index)
                CFG_RAMP_TICKS:   n_cfg.ramp_ticks   = i_data[RATIO_W-1:0];
                CFG_TRIP_CURRENT: n_cfg.trip_current = i_data[TRIP_W-1:0];
                CFG_TRIP_COUNT:   n_cfg.trip_count   = i_data[CNT_W-1:0];
                CFG_FREQ_LOW:     n_cfg.freq_low     = i_data[FREQ_W-1:0];
                CFG_FREQ_HIGH:    n_cfg.freq_high    = i_data[FREQ_W-1:0];
                default:          n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ramp_ticks   <= RAMP_TICKS_RST;
            r_cfg.trip_current <= TRIP_CURRENT_RST;
            r_cfg.trip_count   <= TRIP_COUNT_RST;
            r_cfg.freq_low     <= FREQ_LOW_RST;
            r_cfg.freq_high    <= FREQ_HIGH_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> sv/irs_in_reg.sv
// input register stage holding one command or tick transaction
module irs_in_reg
    import irs_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_stall,
    input  t_item i_item,
    input  logic  i_take,
    output logic  o_valid,
    output t_item o_item
);

    logic  r_valid;
    t_item r_item;
    logic  load;

    assign o_stall = r_valid && !i_take;
    assign load    = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

>>> sv/irs_core.sv
// supervisor state, per-transaction update logic and result register
module irs_core
    import irs_pkg::*;
#(
    parameter int PHASE_TURN = 40000000,
    localparam int PhaseW = $clog2(PHASE_TURN)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  logic              i_valid,
    input  t_item             i_item,
    output logic              o_take,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_result           o_res,
    output logic [PhaseW-1:0] o_phase
);

    // quotient bits needed to reduce a frequency below one turn
    localparam int QuotW = $clog2((1 << FREQ_W) / PHASE_TURN + 1);
    localparam int DW    = FREQ_W + 1;
    localparam int SW    = PhaseW + 1;
    localparam logic [SW-1:0] TurnS = SW'(PHASE_TURN);

    logic               r_enabled;
    logic               r_stop_pending;
    logic               r_fault;
    logic [CNT_W-1:0]   r_over_count;
    logic [RATIO_W-1:0] r_ratio;
    logic [FREQ_W-1:0]  r_target;
    logic [FREQ_W-1:0]  r_actual;
    logic [PhaseW-1:0]  r_phase;

    logic               n_enabled;
    logic               n_stop_pending;
    logic               n_fault;
    logic [CNT_W-1:0]   n_over_count;
    logic [RATIO_W-1:0] n_ratio;
    logic [FREQ_W-1:0]  n_target;
    logic [FREQ_W-1:0]  n_actual;
    logic [PhaseW-1:0]  n_phase;

    logic               r_out_valid;
    t_result            r_res;
    logic [PhaseW-1:0]  r_res_phase;
    t_result            n_res;

    logic               fire;
    logic [CUR_W-1:0]   mag_u;
    logic [CUR_W-1:0]   mag_v;
    logic [CUR_W-1:0]   mag_w;
    logic [CUR_W-1:0]   mag_max;
    logic               over_now;
    logic [CNT_W-1:0]   over_tick;
    logic               trip;
    logic [FREQ_W-1:0]  slew_freq;
    logic [DW-1:0]      freq_rem;
    logic [FREQ_W-1:0]  freq_mod;
    logic [SW-1:0]      phase_sum;
    logic               sum_wrap;
    logic [SW-1:0]      phase_red;
    logic               tick_wrap;
    logic               freq_ok;
    logic               wrapped;
    logic               acc;

    assign fire   = i_valid && (!r_out_valid || !i_out_stall);
    assign o_take = fire;

    // overcurrent detect on the largest phase magnitude
    always_comb begin
        mag_u    = mag16(i_item.phase_u_current);
        mag_v    = mag16(i_item.phase_v_current);
        mag_w    = mag16(i_item.phase_w_current);
        mag_max  = (mag_u > mag_v) ? mag_u : mag_v;
        mag_max  = (mag_w > mag_max) ? mag_w : mag_max;
        over_now = mag_max > {1'b0, i_cfg.trip_current};
        if (!over_now) begin
            over_tick = '0;
        end else if (r_over_count == OVER_MAX) begin
            over_tick = OVER_MAX;
        end else begin
            over_tick = r_over_count + 4'd1;
        end
        trip = over_tick >= i_cfg.trip_count;
    end

    // frequency slew and phase advance with wrap
    always_comb begin
        if (r_target > r_actual) begin
            slew_freq = r_actual + 17'd1;
        end else if (r_target < r_actual) begin
            slew_freq = r_actual - 17'd1;
        end else begin
            slew_freq = r_actual;
        end
        freq_rem = DW'(slew_freq);
        for (int k = QuotW - 1; k >= 0; k--) begin
            if (freq_rem >= (DW'(PHASE_TURN) << k)) begin
                freq_rem = freq_rem - (DW'(PHASE_TURN) << k);
            end
        end
        freq_mod  = freq_rem[FREQ_W-1:0];
        phase_sum = SW'(r_phase) + SW'(freq_mod);
        sum_wrap  = phase_sum >= TurnS;
        phase_red = sum_wrap ? (phase_sum - TurnS) : phase_sum;
        tick_wrap = sum_wrap || (32'(slew_freq) >= 32'(PHASE_TURN));
    end

    assign freq_ok = (i_item.requested_frequency == i_cfg.freq_low) ||
                     (i_item.requested_frequency == i_cfg.freq_high);

    always_comb begin
        n_enabled      = r_enabled;
        n_stop_pending = r_stop_pending;
        n_fault        = r_fault;
        n_over_count   = r_over_count;
        n_ratio        = r_ratio;
        n_target       = r_target;
        n_actual       = r_actual;
        n_phase        = r_phase;
        wrapped        = 1'b0;
        acc            = 1'b0;
        unique case (i_item.operation)
            OP_TICK: begin
                if (r_enabled) begin
                    n_over_count = over_tick;
                    if (trip) begin
                        n_fault   = 1'b1;
                        n_enabled = 1'b0;
                        n_ratio   = '0;
                        n_actual  = r_target;
                    end else if (r_stop_pending && (r_ratio <= 16'd1)) begin
                        n_stop_pending = 1'b0;
                        n_enabled      = 1'b0;
                        n_ratio        = '0;
                        n_actual       = r_target;
                    end else begin
                        if (r_stop_pending) begin
                            n_ratio = r_ratio - 16'd1;
                        end else if (r_ratio < i_cfg.ramp_ticks) begin
                            n_ratio = r_ratio + 16'd1;
                        end
                        n_actual = slew_freq;
                        n_phase  = phase_red[PhaseW-1:0];
                        wrapped  = tick_wrap;
                    end
                end
            end
            OP_START: begin
                if (!r_fault && !r_enabled) begin
                    n_ratio        = '0;
                    n_stop_pending = 1'b0;
                    n_over_count   = '0;
                    n_phase        = '0;
                    n_enabled      = 1'b1;
                    acc            = 1'b1;
                end
            end
            OP_STOP: begin
                if (r_enabled && !r_fault) begin
                    n_stop_pending = 1'b1;
                    acc            = 1'b1;
                end
            end
            OP_CLR_FAULT: begin
                if (r_fault) begin
                    n_over_count = '0;
                    n_fault      = 1'b0;
                    acc          = 1'b1;
                end
            end
            OP_SET_FREQ: begin
                if (freq_ok) begin
                    n_target = i_item.requested_frequency;
                    if (!r_enabled) begin
                        n_actual = i_item.requested_frequency;
                    end
                    acc = 1'b1;
                end
            end
            default: begin
                acc = 1'b0;
            end
        endcase
    end

    always_comb begin
        priority if (!n_enabled) begin
            n_res.run_mode = ST_STOP;
        end else if (n_stop_pending) begin
            n_res.run_mode = ST_RAMP_DOWN;
        end else if (n_ratio < i_cfg.ramp_ticks) begin
            n_res.run_mode = ST_RAMP_UP;
        end else if (n_actual != n_target) begin
            n_res.run_mode = ST_RAMP_FREQ;
        end else begin
            n_res.run_mode = ST_RUN;
        end
        n_res.fault_flag        = n_fault;
        n_res.output_enable     = n_enabled;
        n_res.amplitude_ratio   = n_ratio;
        n_res.present_frequency = n_actual;
        n_res.cycle_done        = wrapped;
        n_res.accepted          = acc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled      <= 1'b0;
            r_stop_pending <= 1'b0;
            r_fault        <= 1'b0;
            r_over_count   <= '0;
            r_ratio        <= '0;
            r_target       <= FREQ_RST;
            r_actual       <= FREQ_RST;
            r_phase        <= '0;
        end else if (fire) begin
            r_enabled      <= n_enabled;
            r_stop_pending <= n_stop_pending;
            r_fault        <= n_fault;
            r_over_count   <= n_over_count;
            r_ratio        <= n_ratio;
            r_target       <= n_target;
            r_actual       <= n_actual;
            r_phase        <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_res       <= n_res;
            r_res_phase <= n_phase;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_res       = r_res;
    assign o_phase     = r_res_phase;

endmodule

>>> sv/inverter_run_supervisor.sv
// top level of the inverter run supervisor
//
// usage notes
// - input channel: one transaction per command or control tick, taken on a rising
//   edge with i_in_valid high and o_in_stall low; operation selects tick, start,
//   stop, clear fault or set frequency, the currents count on a tick only
// - output channel: exactly one result transaction per input transaction, in order,
//   delivered on a rising edge with o_out_valid high and i_out_stall low
// - configuration: i_cfg_index / i_cfg_data written while i_cfg_valid and
//   o_cfg_ready are high; ready is always high, write only while the block is idle
// - path: a transaction is held in the input register, then passes through the update
//   logic into the result register, which drives the outputs
// - throughput: one transaction per clock unless the receiver stalls; the state update is a
//   single pass of compare, increment and a short wrap reduction of the phase accumulator
// - a receiver stall holds the result register; the input register still takes one
//   more transaction, after which o_in_stall rises until the result is taken
// - reset (synchronous, active low): outputs disabled, no fault, ratio and phase
//   zero, target and present frequency at 120000, registers at their default values
module inverter_run_supervisor
    import irs_pkg::*;
#(
    parameter int PHASE_TURN = 40000000,
    localparam int PhaseW = $clog2(PHASE_TURN)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input channel
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [OP_W-1:0]       i_operation,
    input  logic signed [CUR_W-1:0] i_phase_u_current,
    input  logic signed [CUR_W-1:0] i_phase_v_current,
    input  logic signed [CUR_W-1:0] i_phase_w_current,
    input  logic [FREQ_W-1:0]     i_requested_frequency,
    // output channel
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [STATE_W-1:0]    o_run_mode,
    output logic                  o_fault_flag,
    output logic                  o_output_enable,
    output logic [RATIO_W-1:0]    o_amplitude_ratio,
    output logic [FREQ_W-1:0]     o_present_frequency,
    output logic [PhaseW-1:0]     o_phase_angle,
    output logic                  o_cycle_done,
    output logic                  o_accepted,
    // configuration write channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg    cfg;
    t_item   in_item;
    t_item   stage_item;
    logic    stage_valid;
    logic    stage_take;
    t_result res;

    // registers accept a write on every cycle
    assign o_cfg_ready = 1'b1;

    irs_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid && o_cfg_ready),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    // pack the payload ports into one transaction
    always_comb begin
        in_item.operation           = i_operation;
        in_item.phase_u_current     = i_phase_u_current;
        in_item.phase_v_current     = i_phase_v_current;
        in_item.phase_w_current     = i_phase_w_current;
        in_item.requested_frequency = i_requested_frequency;
    end

    irs_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_item  (in_item),
        .i_take  (stage_take),
        .o_valid (stage_valid),
        .o_item  (stage_item)
    );

    // state update and result register; a transaction moves on when the result
    // register is empty or being emptied
    irs_core #(
        .PHASE_TURN (PHASE_TURN)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_valid     (stage_valid),
        .i_item      (stage_item),
        .o_take      (stage_take),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_res       (res),
        .o_phase     (o_phase_angle)
    );

    assign o_run_mode          = res.run_mode;
    assign o_fault_flag        = res.fault_flag;
    assign o_output_enable     = res.output_enable;
    assign o_amplitude_ratio   = res.amplitude_ratio;
    assign o_present_frequency = res.present_frequency;
    assign o_cycle_done        = res.cycle_done;
    assign o_accepted          = res.accepted;

endmodule

>>> sv/irs_checker.sv
// port-level checker for the inverter run supervisor, bound to the top level
`include "inverter_run_supervisor_defines.svh"

module irs_checker
    import irs_pkg::*;
#(
    parameter int PHASE_TURN = 40000000,
    localparam int PhaseW = $clog2(PHASE_TURN)
) (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_in_valid,
    input logic                    o_in_stall,
    input logic [OP_W-1:0]         i_operation,
    input logic signed [CUR_W-1:0] i_phase_u_current,
    input logic signed [CUR_W-1:0] i_phase_v_current,
    input logic signed [CUR_W-1:0] i_phase_w_current,
    input logic [FREQ_W-1:0]       i_requested_frequency,
    input logic                    o_out_valid,
    input logic                    i_out_stall,
    input logic [STATE_W-1:0]      o_run_mode,
    input logic                    o_fault_flag,
    input logic                    o_output_enable,
    input logic [RATIO_W-1:0]      o_amplitude_ratio,
    input logic [FREQ_W-1:0]       o_present_frequency,
    input logic [PhaseW-1:0]       o_phase_angle,
    input logic                    o_cycle_done,
    input logic                    o_accepted,
    input logic                    i_cfg_valid,
    input logic                    o_cfg_ready,
    input logic [CFG_IDX_W-1:0]    i_cfg_index,
    input logic [CFG_DATA_W-1:0]   i_cfg_data
);

    // a stalled result stays offered, with its phase angle and amplitude ratio unchanged
    `IRS_ASSERT_NEXT(a_res_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_phase_angle) && $stable(o_amplitude_ratio), "stalled result changed")

    // a latched fault always has the outputs off
    `IRS_ASSERT_NOW(a_fault_off, o_out_valid && o_fault_flag, !o_output_enable, "fault with outputs enabled")

    // stop state and disabled outputs go together, and a stopped bridge has zero ratio
    `IRS_ASSERT_NOW(a_stop_state, o_out_valid && !o_output_enable, (o_run_mode == ST_STOP) && (o_amplitude_ratio == '0), "disabled outputs not in stop state")

    // a phase wrap comes only from a tick with the outputs still running
    `IRS_ASSERT_NOW(a_wrap_tick, o_out_valid && o_cycle_done, o_output_enable && !o_accepted, "cycle flag outside a running tick")

endmodule

bind inverter_run_supervisor irs_checker #(.PHASE_TURN(PHASE_TURN)) u_irs_checker (.*);
